// ===== hw/rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps
package sfa_pkg;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam logic [ExpW-1:0] ExpMax = 8'hff;
  localparam logic [ExpW-1:0] ExpZero = 8'h00;

  // Count leading zeros of a 25-bit magnitude below the carry bit (bits 23:0).
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

// ===== hw/rtl/sfa_if.sv =====
`timescale 1ns / 1ps
interface sfa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;
  modport source (output valid, output sum_bits, input ready);
  modport sink (input valid, input sum_bits, output ready);
endinterface

// ===== hw/rtl/single_float_adder_top.sv =====
`timescale 1ns / 1ps
// Single-precision adder, truncating, no denormals.
// Channels: in_ch carries operand_a and operand_b; out_ch carries sum_bits.
// Both use valid/ready; an item moves on an edge where both are high.
// Stages:
//   1: unpack, special-case detection, two's complement, exponent compare
//   2: align the smaller mantissa (arithmetic right shift, saturating at 31)
//   3: add, take sign and magnitude, count leading zeros
//   4: normalise and pack (this is the output register)
// The accepting edge loads stage 1; the item then passes through stages 2, 3
// and 4 in turn, and out valid rises once it sits in stage 4. Throughput is one
// item per cycle while out_ch.ready stays high; every stage holds one item.
// Special cases (zero or all-ones exponent) bypass the arithmetic and ride
// down the pipe in pass-through registers.
// Reset clears every stage valid bit; the block takes items from the first
// edge after rst_ni rises.
// When the receiver stalls, full stages hold: a stage advances only if it is
// empty or the stage after it is moving, so nothing is lost or repeated.
module single_float_adder_top (
  input  logic clk_i,
  input  logic rst_ni,
  sfa_in_if.sink    in_ch,
  sfa_out_if.source out_ch
);
  import sfa_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || out_ch.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ch.ready = adv1;

  // Stage 1 signals
  logic [ExpW-1:0] ea, eb;
  logic signed [25:0] ma, mb;
  logic byp_d;
  logic [31:0] bypv_d;

  always_comb begin
    ea = in_ch.operand_a[30:23];
    eb = in_ch.operand_b[30:23];
    ma = {3'b001, in_ch.operand_a[22:0]};
    mb = {3'b001, in_ch.operand_b[22:0]};
    if (in_ch.operand_a[31]) ma = -ma;
    if (in_ch.operand_b[31]) mb = -mb;
    byp_d = 1'b1;
    priority if (ea == ExpZero) bypv_d = in_ch.operand_b;
    else if (eb == ExpZero) bypv_d = in_ch.operand_a;
    else if (ea == ExpMax) bypv_d = in_ch.operand_a;
    else if (eb == ExpMax) bypv_d = in_ch.operand_b;
    else begin
      bypv_d = in_ch.operand_a;
      byp_d = 1'b0;
    end
  end

  logic               byp1_q;
  logic [31:0]        bypv1_q;
  logic signed [25:0] big1_q, sml1_q;
  logic [ExpW-1:0]    er1_q;
  logic [4:0]         sh1_q;
  logic [ExpW-1:0]    diff;
  logic               a_ge;

  assign a_ge = ea >= eb;
  assign diff = a_ge ? ea - eb : eb - ea;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      byp1_q  <= byp_d;
      bypv1_q <= bypv_d;
      big1_q  <= a_ge ? ma : mb;
      sml1_q  <= a_ge ? mb : ma;
      er1_q   <= a_ge ? ea : eb;
      sh1_q   <= (diff > 8'd31) ? 5'd31 : diff[4:0];
    end
  end

  // Stage 2: align
  logic               byp2_q;
  logic [31:0]        bypv2_q;
  logic signed [25:0] big2_q, sml2_q;
  logic [ExpW-1:0]    er2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      byp2_q  <= byp1_q;
      bypv2_q <= bypv1_q;
      big2_q  <= big1_q;
      sml2_q  <= sml1_q >>> sh1_q;
      er2_q   <= er1_q;
    end
  end

  // Stage 3: add, sign/magnitude, leading-zero count
  logic signed [25:0] sum;
  logic [24:0]        mag;
  assign sum = big2_q + sml2_q;
  assign mag = sum[25] ? 25'(-sum) : sum[24:0];

  logic            byp3_q, sr3_q;
  logic [31:0]     bypv3_q;
  logic [24:0]     mag3_q;
  logic [4:0]      lz3_q;
  logic [ExpW-1:0] er3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      byp3_q  <= byp2_q;
      bypv3_q <= bypv2_q;
      sr3_q   <= sum[25];
      mag3_q  <= mag;
      lz3_q   <= lzc24(mag[23:0]);
      er3_q   <= er2_q;
    end
  end

  // Stage 4: normalise and pack
  logic [31:0] res_d;
  logic [24:0] nm;
  logic [ExpW-1:0] en;

  always_comb begin
    nm = mag3_q << lz3_q;
    en = er3_q - ExpW'(lz3_q);
    if (mag3_q[24]) begin
      nm = mag3_q >> 1;
      en = er3_q + 8'd1;
    end
    if (byp3_q) res_d = bypv3_q;
    else if (mag3_q == 25'd0) res_d = 32'd0;
    else res_d = {sr3_q, en, nm[22:0]};
  end

  logic [31:0] res4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) res4_q <= res_d;
  end

  assign out_ch.valid    = v4_q;
  assign out_ch.sum_bits = res4_q;

  // Hold the output while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ch.ready |=> v4_q && $stable(res4_q))
    else $error("output changed under stall");
  // Full pipe with stalled output must refuse input.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && !out_ch.ready |-> !in_ch.ready)
    else $error("accepted into a full pipe");
  // Accepted item reaches stage one.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> v1_q)
    else $error("accepted item lost");
endmodule
